// ===== hw/rtl/c8alu_pkg.sv =====
package c8alu_pkg;

   // Operation codes carried in the cmd field.
   typedef enum logic [4:0] {
      CMD_ADC  = 5'd0,
      CMD_SBC  = 5'd1,
      CMD_AND  = 5'd2,
      CMD_ORA  = 5'd3,
      CMD_EOR  = 5'd4,
      CMD_CMP  = 5'd5,
      CMD_CPX  = 5'd6,
      CMD_CPY  = 5'd7,
      CMD_BIT  = 5'd8,
      CMD_LDA  = 5'd9,
      CMD_LDX  = 5'd10,
      CMD_LDY  = 5'd11,
      CMD_INC  = 5'd12,
      CMD_DEC  = 5'd13,
      CMD_ASL  = 5'd14,
      CMD_LSR  = 5'd15,
      CMD_ROL  = 5'd16,
      CMD_ROR  = 5'd17,
      CMD_TRB  = 5'd18,
      CMD_TSB  = 5'd19,
      CMD_RMB  = 5'd20,
      CMD_SMB  = 5'd21,
      CMD_BBX  = 5'd22,
      CMD_SEC  = 5'd23,
      CMD_CLC  = 5'd24,
      CMD_SEI  = 5'd25,
      CMD_CLI  = 5'd26,
      CMD_CLV  = 5'd27,
      CMD_SED  = 5'd28,
      CMD_CLD  = 5'd29,
      CMD_PLP  = 5'd30
   } cmd_type;

   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 3;

   // Packed status bit positions.
   localparam int ST_C = 0;
   localparam int ST_Z = 1;
   localparam int ST_I = 2;
   localparam int ST_D = 3;
   localparam int ST_V = 6;
   localparam int ST_N = 7;

   // BCD correction constants.
   localparam logic [3:0]  BCD_DIGIT_MAX = 4'h9;
   localparam logic [15:0] BCD_LO_FIX    = 16'h0006;
   localparam logic [15:0] BCD_HI_FIX    = 16'h0060;

endpackage

// ===== hw/rtl/c8alu_if.sv =====
interface c8alu_req_if;
   logic                              valid;
   logic                              ready;
   c8alu_pkg::cmd_type                cmd;
   logic [c8alu_pkg::BYTE_W-1:0]      operand;
   logic [c8alu_pkg::INDEX_W-1:0]     bit_index;

   modport source (output valid, output cmd, output operand, output bit_index, input ready);
   modport sink   (input valid, input cmd, input operand, input bit_index, output ready);
endinterface

interface c8alu_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [c8alu_pkg::BYTE_W-1:0]      acc_out;
   logic [c8alu_pkg::BYTE_W-1:0]      x_out;
   logic [c8alu_pkg::BYTE_W-1:0]      y_out;
   logic [c8alu_pkg::BYTE_W-1:0]      status_out;
   logic [c8alu_pkg::BYTE_W-1:0]      mem_out;
   logic                              bit_is_set;

   modport source (output valid, output acc_out, output x_out, output y_out,
                   output status_out, output mem_out, output bit_is_set, input ready);
   modport sink   (input valid, input acc_out, input x_out, input y_out,
                   input status_out, input mem_out, input bit_is_set, output ready);
endinterface

// ===== hw/rtl/cpu8_alu_with_bcd_flags.sv =====
// Channel   Modport  Direction  Contents
// req_ch    sink     in         cmd, operand, bit_index
// rsp_ch    source   out        acc_out, x_out, y_out, status_out, mem_out, bit_is_set
//
// One item is taken per cycle while the result side does not stall; an accepted transfer
// goes into the input stage and from there into the result register, which offers it.
// The rate is set by the single ALU pass that reads the architectural registers and
// writes them back together with the result register in the same cycle.
// Reset (synchronous, active high) empties both stages and sets A, X, Y to zero,
// Z and I to one and the other flags to zero.
// A stall on the result side holds the result; the input stage then holds its item
// and drops req_ch.ready until the result moves on.
module cpu8_alu_with_bcd_flags (
   input  logic              clock,
   input  logic              reset,
   c8alu_req_if.sink         req_ch,
   c8alu_rsp_if.source       rsp_ch
);
   import c8alu_pkg::*;

   // Input stage.
   logic                 in_valid_ff, in_valid_in;
   cmd_type              cmd_ff;
   logic [BYTE_W-1:0]    operand_ff;
   logic [INDEX_W-1:0]   bit_index_ff;

   // Result stage.
   logic                 out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]    acc_res_ff, x_res_ff, y_res_ff, status_res_ff, mem_res_ff;
   logic                 bit_res_ff;

   // Architectural state.
   logic [BYTE_W-1:0]    acc_ff, acc_in;
   logic [BYTE_W-1:0]    x_ff, x_in;
   logic [BYTE_W-1:0]    y_ff, y_in;
   logic                 n_ff, n_in, v_ff, v_in, z_ff, z_in;
   logic                 c_ff, c_in, d_ff, d_in, i_ff, i_in;

   logic                 advance;
   logic                 req_take;
   logic [BYTE_W-1:0]    mem_in;
   logic [BYTE_W-1:0]    status_in;
   logic                 bit_in;
   logic [BYTE_W-1:0]    mask;
   logic [BYTE_W-1:0]    op;

   // Binary adder, also used for binary SBC with the operand complemented.
   logic [BYTE_W-1:0]    add_operand;
   logic [BYTE_W:0]      bin_sum;
   // Decimal add.
   logic [5:0]           dadd_lo;
   logic [9:0]           dadd_sum;
   logic                 dadd_hi_fix;
   logic [9:0]           dadd_fixed;
   // Decimal subtract, kept at 16 bits so the carry comes from bit 15.
   logic [15:0]          dsub_lo_raw, dsub_lo, dsub_raw, dsub_r;
   // Compare.
   logic [BYTE_W-1:0]    cmp_reg;
   logic [BYTE_W:0]      cmp_diff;
   logic [BYTE_W-1:0]    add_res;
   logic [BYTE_W-1:0]    sub_res;

   // An item moves into the result register when that register is empty or being drained.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !in_valid_ff || advance;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   assign op   = operand_ff;
   assign mask = BYTE_W'(1) << bit_index_ff;

   // Binary ADC/SBC.
   assign add_operand = (cmd_ff == CMD_SBC) ? ~op : op;
   assign bin_sum     = {1'b0, acc_ff} + {1'b0, add_operand} + {{BYTE_W{1'b0}}, c_ff};

   // Decimal ADC: correct the low digit, add the high digits, then correct the high digit.
   always_comb begin
      dadd_lo = {2'b00, acc_ff[3:0]} + {2'b00, op[3:0]} + {5'b0, c_ff};
      if (dadd_lo > 6'(BCD_DIGIT_MAX)) begin
         dadd_lo = dadd_lo + 6'(BCD_LO_FIX);
      end
      dadd_sum    = {2'b00, acc_ff[7:4], 4'b0} + {2'b00, op[7:4], 4'b0} + {4'b0, dadd_lo};
      dadd_hi_fix = ({dadd_sum[9:4], 4'b0} > 10'h090);
      dadd_fixed  = dadd_hi_fix ? dadd_sum + 10'(BCD_HI_FIX) : dadd_sum;
   end

   // Decimal SBC: same shape, wrapping at 16 bits.
   always_comb begin
      dsub_lo_raw = {12'b0, acc_ff[3:0]} - {12'b0, op[3:0]} - {15'b0, !c_ff};
      dsub_lo     = (dsub_lo_raw > 16'(BCD_DIGIT_MAX)) ? dsub_lo_raw - BCD_LO_FIX
                                                      : dsub_lo_raw;
      dsub_raw    = {8'b0, acc_ff[7:4], 4'b0} - {8'b0, op[7:4], 4'b0} + dsub_lo;
      dsub_r      = (dsub_raw[7:4] > BCD_DIGIT_MAX) ? dsub_raw - BCD_HI_FIX : dsub_raw;
   end

   assign add_res = d_ff ? dadd_fixed[7:0] : bin_sum[7:0];
   assign sub_res = d_ff ? dsub_r[7:0] : bin_sum[7:0];

   always_comb begin
      case (cmd_ff)
         CMD_CPX: cmp_reg = x_ff;
         CMD_CPY: cmp_reg = y_ff;
         default: cmp_reg = acc_ff;
      endcase
   end
   assign cmp_diff = {1'b0, cmp_reg} - {1'b0, op};

   // Operation decode; registers and flags not named keep their values, mem_in is zero.
   always_comb begin
      acc_in = acc_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      n_in   = n_ff;
      v_in   = v_ff;
      z_in   = z_ff;
      c_in   = c_ff;
      d_in   = d_ff;
      i_in   = i_ff;
      mem_in = '0;
      unique case (cmd_ff)
         CMD_ADC: begin
            acc_in = add_res;
            c_in   = d_ff ? dadd_hi_fix : bin_sum[BYTE_W];
            v_in   = (op[7] ^ add_res[7]) & (acc_ff[7] ^ add_res[7]);
            n_in   = add_res[7];
            z_in   = (add_res == '0);
         end
         CMD_SBC: begin
            acc_in = sub_res;
            c_in   = d_ff ? !dsub_r[15] : bin_sum[BYTE_W];
            // Binary SBC takes V from the complemented operand, decimal from the operand.
            v_in   = ((d_ff ? op[7] : ~op[7]) ^ sub_res[7]) & (acc_ff[7] ^ sub_res[7]);
            n_in   = sub_res[7];
            z_in   = (sub_res == '0);
         end
         CMD_AND: begin
            acc_in = acc_ff & op;
            n_in   = acc_in[7];
            z_in   = (acc_in == '0);
         end
         CMD_ORA: begin
            acc_in = acc_ff | op;
            n_in   = acc_in[7];
            z_in   = (acc_in == '0);
         end
         CMD_EOR: begin
            acc_in = acc_ff ^ op;
            n_in   = acc_in[7];
            z_in   = (acc_in == '0);
         end
         CMD_CMP, CMD_CPX, CMD_CPY: begin
            c_in = !cmp_diff[BYTE_W];
            n_in = cmp_diff[7];
            z_in = (cmp_diff[7:0] == '0);
         end
         CMD_BIT: begin
            z_in = ((acc_ff & op) == '0);
            n_in = op[7];
            v_in = op[6];
         end
         CMD_LDA: begin
            acc_in = op;
            n_in   = op[7];
            z_in   = (op == '0);
         end
         CMD_LDX: begin
            x_in = op;
            n_in = op[7];
            z_in = (op == '0);
         end
         CMD_LDY: begin
            y_in = op;
            n_in = op[7];
            z_in = (op == '0);
         end
         CMD_INC: begin
            mem_in = op + 8'd1;
            n_in   = mem_in[7];
            z_in   = (mem_in == '0);
         end
         CMD_DEC: begin
            mem_in = op - 8'd1;
            n_in   = mem_in[7];
            z_in   = (mem_in == '0);
         end
         CMD_ASL: begin
            mem_in = {op[6:0], 1'b0};
            c_in   = op[7];
            n_in   = mem_in[7];
            z_in   = (mem_in == '0);
         end
         CMD_LSR: begin
            mem_in = {1'b0, op[7:1]};
            c_in   = op[0];
            n_in   = mem_in[7];
            z_in   = (mem_in == '0);
         end
         CMD_ROL: begin
            mem_in = {op[6:0], c_ff};
            c_in   = op[7];
            n_in   = mem_in[7];
            z_in   = (mem_in == '0);
         end
         CMD_ROR: begin
            mem_in = {c_ff, op[7:1]};
            c_in   = op[0];
            n_in   = mem_in[7];
            z_in   = (mem_in == '0);
         end
         CMD_TRB: begin
            z_in   = ((acc_ff & op) == '0);
            mem_in = ~acc_ff & op;
         end
         CMD_TSB: begin
            z_in   = ((acc_ff & op) == '0);
            mem_in = acc_ff | op;
         end
         CMD_RMB: mem_in = op & ~mask;
         CMD_SMB: mem_in = op | mask;
         CMD_BBX: ;
         CMD_SEC: c_in = 1'b1;
         CMD_CLC: c_in = 1'b0;
         CMD_SEI: i_in = 1'b1;
         CMD_CLI: i_in = 1'b0;
         CMD_CLV: v_in = 1'b0;
         CMD_SED: d_in = 1'b1;
         CMD_CLD: d_in = 1'b0;
         CMD_PLP: begin
            // Bits 4 and 5 of the pulled byte have no flag behind them.
            c_in = op[ST_C];
            z_in = op[ST_Z];
            i_in = op[ST_I];
            d_in = op[ST_D];
            v_in = op[ST_V];
            n_in = op[ST_N];
         end
         default: ;
      endcase
   end

   assign status_in = {n_in, v_in, 1'b1, 1'b1, d_in, i_in, z_in, c_in};
   assign bit_in    = op[bit_index_ff];

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         n_ff         <= 1'b0;
         v_ff         <= 1'b0;
         z_ff         <= 1'b1;
         c_ff         <= 1'b0;
         d_ff         <= 1'b0;
         i_ff         <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            acc_ff <= acc_in;
            x_ff   <= x_in;
            y_ff   <= y_in;
            n_ff   <= n_in;
            v_ff   <= v_in;
            z_ff   <= z_in;
            c_ff   <= c_in;
            d_ff   <= d_in;
            i_ff   <= i_in;
         end
      end
   end

   // Payload registers of both stages.
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff       <= req_ch.cmd;
         operand_ff   <= req_ch.operand;
         bit_index_ff <= req_ch.bit_index;
      end
      if (advance) begin
         acc_res_ff    <= acc_in;
         x_res_ff      <= x_in;
         y_res_ff      <= y_in;
         status_res_ff <= status_in;
         mem_res_ff    <= mem_in;
         bit_res_ff    <= bit_in;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.acc_out    = acc_res_ff;
   assign rsp_ch.x_out      = x_res_ff;
   assign rsp_ch.y_out      = y_res_ff;
   assign rsp_ch.status_out = status_res_ff;
   assign rsp_ch.mem_out    = mem_res_ff;
   assign rsp_ch.bit_is_set = bit_res_ff;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import c8alu_pkg::*;

   typedef logic [BYTE_W-1:0] byte_type;

   // One expected result: the register file after the operation, the packed
   // status, the modified memory byte and the selected operand bit.
   typedef struct packed {
      byte_type acc;
      byte_type x;
      byte_type y;
      byte_type status;
      byte_type mem;
      logic     bit_set;
   } alu_result_type;

   // Run control. The limit covers every item taking the longest sender gap,
   // the longest receiver stall and the pipeline latency, several times over.
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int HOLD_OFF_LEN   = 200;
   localparam int MAX_PRINTED    = 40;
   localparam int BCD_HI_LIMIT   = 'h90;
   localparam int SBC_BORROW_LIM = 'h8000;

   logic clock;
   logic reset;

   c8alu_req_if req_ch ();
   c8alu_rsp_if rsp_ch ();

   cpu8_alu_with_bcd_flags DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // 10 ns clock, one delay for each half period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Shadow copy of the architectural state, advanced once per accepted
   // transfer on the input side.
   byte_type reg_a;
   byte_type reg_x;
   byte_type reg_y;
   logic  flag_n;
   logic  flag_v;
   logic  flag_z;
   logic  flag_c;
   logic  flag_d;
   logic  flag_i;

   // Results predicted but not yet seen on the output side, oldest first.
   alu_result_type pending_results[$];

   int mismatch_count  = 0;
   int results_checked = 0;
   int items_sent      = 0;
   int decimal_items   = 0;
   int cycle_count     = 0;

   // Knobs shared between the test tasks, the input driver and the output ready process.
   bit sender_gaps_on   = 1'b0;
   bit receiver_gaps_on = 1'b0;
   int hold_cycles      = 0;

   // ---------------------------------------------------------------------
   // ALU predictor
   // ---------------------------------------------------------------------

   function automatic void clear_alu_state();
      reg_a  = '0;
      reg_x  = '0;
      reg_y  = '0;
      flag_n = 1'b0;
      flag_v = 1'b0;
      flag_z = 1'b1;
      flag_c = 1'b0;
      flag_d = 1'b0;
      flag_i = 1'b1;
   endfunction

   function automatic void update_nz(input byte_type value);
      flag_n = value[7];
      flag_z = (value == '0);
   endfunction

   // Addition with carry in. In decimal mode each nibble is corrected on its
   // own; the carry comes only from the high correction and is cleared when
   // no high correction takes place.
   function automatic void add_to_acc(input byte_type value);
      byte_type a_old;
      byte_type sum8;
      byte_type v_bits;
      int    ia;
      int    iv;
      int    sum;
      a_old = reg_a;
      ia    = int'(a_old);
      iv    = int'(value);
      if (!flag_d) begin
         sum    = ia + iv + int'(flag_c);
         flag_c = (sum > 'hFF);
      end else begin
         sum = (ia & 'h0F) + (iv & 'h0F) + int'(flag_c);
         if (sum > int'(BCD_DIGIT_MAX))
            sum += int'(BCD_LO_FIX);
         sum = (ia & 'hF0) + (iv & 'hF0) + sum;
         if ((sum & 'hFF0) > BCD_HI_LIMIT) begin
            sum += int'(BCD_HI_FIX);
            flag_c = 1'b1;
         end else begin
            flag_c = 1'b0;
         end
      end
      sum8   = byte_type'(sum);
      reg_a  = sum8;
      v_bits = (value ^ sum8) & (a_old ^ sum8);
      flag_v = v_bits[7];
      update_nz(sum8);
   endfunction

   // Subtraction. Binary mode adds the complemented operand; decimal mode
   // works on a 16-bit wrapping difference and takes the carry from its sign.
   function automatic void subtract_from_acc(input byte_type value);
      byte_type a_old;
      byte_type diff8;
      byte_type v_bits;
      int    ia;
      int    iv;
      int    lo;
      int    diff;
      if (!flag_d) begin
         add_to_acc(~value);
         return;
      end
      a_old = reg_a;
      ia    = int'(a_old);
      iv    = int'(value);
      lo    = ((ia & 'h0F) - (iv & 'h0F) - (flag_c ? 0 : 1)) & 'hFFFF;
      if (lo > int'(BCD_DIGIT_MAX))
         lo = (lo - int'(BCD_LO_FIX)) & 'hFFFF;
      diff = ((ia & 'hF0) - (iv & 'hF0) + lo) & 'hFFFF;
      if ((diff & 'hF0) > BCD_HI_LIMIT)
         diff = (diff - int'(BCD_HI_FIX)) & 'hFFFF;
      flag_c = (diff < SBC_BORROW_LIM);
      diff8  = byte_type'(diff);
      reg_a  = diff8;
      v_bits = (value ^ diff8) & (a_old ^ diff8);
      flag_v = v_bits[7];
      update_nz(diff8);
   endfunction

   function automatic void compare_with(input byte_type register_value, input byte_type value);
      flag_c = (register_value >= value);
      update_nz(register_value - value);
   endfunction

   // Applies one operation to the shadow state and returns what the block
   // must report for it.
   function automatic alu_result_type alu_execute(input cmd_type op, input byte_type opnd,
                                                  input logic [INDEX_W-1:0] bsel);
      alu_result_type res;
      byte_type       mask;
      byte_type       mem_byte;
      logic           carry_in;
      mask     = byte_type'(1) << bsel;
      mem_byte = '0;
      carry_in = flag_c;
      case (op)
         CMD_ADC: add_to_acc(opnd);
         CMD_SBC: subtract_from_acc(opnd);
         CMD_AND: begin
            reg_a = reg_a & opnd;
            update_nz(reg_a);
         end
         CMD_ORA: begin
            reg_a = reg_a | opnd;
            update_nz(reg_a);
         end
         CMD_EOR: begin
            reg_a = reg_a ^ opnd;
            update_nz(reg_a);
         end
         CMD_CMP: compare_with(reg_a, opnd);
         CMD_CPX: compare_with(reg_x, opnd);
         CMD_CPY: compare_with(reg_y, opnd);
         CMD_BIT: begin
            flag_z = ((reg_a & opnd) == '0);
            flag_n = opnd[7];
            flag_v = opnd[6];
         end
         CMD_LDA: begin
            reg_a = opnd;
            update_nz(opnd);
         end
         CMD_LDX: begin
            reg_x = opnd;
            update_nz(opnd);
         end
         CMD_LDY: begin
            reg_y = opnd;
            update_nz(opnd);
         end
         CMD_INC: begin
            mem_byte = opnd + 8'd1;
            update_nz(mem_byte);
         end
         CMD_DEC: begin
            mem_byte = opnd - 8'd1;
            update_nz(mem_byte);
         end
         CMD_ASL: begin
            mem_byte = {opnd[6:0], 1'b0};
            flag_c   = opnd[7];
            update_nz(mem_byte);
         end
         CMD_LSR: begin
            mem_byte = {1'b0, opnd[7:1]};
            flag_c   = opnd[0];
            update_nz(mem_byte);
         end
         CMD_ROL: begin
            mem_byte = {opnd[6:0], carry_in};
            flag_c   = opnd[7];
            update_nz(mem_byte);
         end
         CMD_ROR: begin
            mem_byte = {carry_in, opnd[7:1]};
            flag_c   = opnd[0];
            update_nz(mem_byte);
         end
         CMD_TRB: begin
            flag_z   = ((reg_a & opnd) == '0);
            mem_byte = ~reg_a & opnd;
         end
         CMD_TSB: begin
            flag_z   = ((reg_a & opnd) == '0);
            mem_byte = reg_a | opnd;
         end
         CMD_RMB: mem_byte = opnd & ~mask;
         CMD_SMB: mem_byte = opnd | mask;
         CMD_BBX: ;
         CMD_SEC: flag_c = 1'b1;
         CMD_CLC: flag_c = 1'b0;
         CMD_SEI: flag_i = 1'b1;
         CMD_CLI: flag_i = 1'b0;
         CMD_CLV: flag_v = 1'b0;
         CMD_SED: flag_d = 1'b1;
         CMD_CLD: flag_d = 1'b0;
         CMD_PLP: begin
            // Bits 4 and 5 of the pulled byte have no flag behind them.
            flag_c = opnd[ST_C];
            flag_z = opnd[ST_Z];
            flag_i = opnd[ST_I];
            flag_d = opnd[ST_D];
            flag_v = opnd[ST_V];
            flag_n = opnd[ST_N];
         end
         default: ;
      endcase
      res.acc          = reg_a;
      res.x            = reg_x;
      res.y            = reg_y;
      res.status       = 8'h30;
      res.status[ST_N] = flag_n;
      res.status[ST_V] = flag_v;
      res.status[ST_D] = flag_d;
      res.status[ST_I] = flag_i;
      res.status[ST_Z] = flag_z;
      res.status[ST_C] = flag_c;
      res.mem          = mem_byte;
      res.bit_set      = opnd[bsel];
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Random helpers
   // ---------------------------------------------------------------------

   // Most gaps and stalls are short; roughly one in five is long.
   function automatic int pick_gap_length();
      if ($urandom_range(0, 9) < 8)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // arith_pct percent of the picks are ADC or SBC, the rest spread evenly
   // over all codes so that the flag operations keep toggling decimal mode.
   function automatic cmd_type pick_cmd(input int arith_pct);
      if ($urandom_range(0, 99) < arith_pct)
         return ($urandom_range(0, 1) != 0) ? CMD_SBC : CMD_ADC;
      return cmd_type'($urandom_range(0, 30));
   endfunction

   // In decimal mode most operands are valid packed BCD so that the nibble
   // corrections are exercised on the values they are meant for.
   function automatic byte_type pick_operand(input bit bcd_bias);
      if (bcd_bias && $urandom_range(0, 99) < 75)
         return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      return byte_type'($urandom_range(0, 255));
   endfunction

   // ---------------------------------------------------------------------
   // Input channel driver
   // ---------------------------------------------------------------------

   // Offers one item, optionally after an idle gap, and waits for the
   // transfer. Valid is left high so that back-to-back items keep it up
   // without a low pulse; the prediction is made at the accepting edge.
   task automatic send_op(input cmd_type op, input byte_type opnd,
                          input logic [INDEX_W-1:0] bsel);
      int gap;
      gap = (sender_gaps_on && $urandom_range(0, 99) < 35) ? pick_gap_length() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.cmd       <= op;
      req_ch.operand   <= opnd;
      req_ch.bit_index <= bsel;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      if (flag_d && (op == CMD_ADC || op == CMD_SBC))
         decimal_items++;
      pending_results.push_back(alu_execute(op, opnd, bsel));
      items_sent++;
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   task automatic wait_all_results();
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic send_random_ops(input int count, input int arith_pct);
      repeat (count)
         send_op(pick_cmd(arith_pct), pick_operand(flag_d), INDEX_W'($urandom_range(0, 7)));
   endtask

   // ---------------------------------------------------------------------
   // Output channel: ready generation and result checking
   // ---------------------------------------------------------------------

   // The receiver stalls at random while gaps are enabled, and holds off whenever a
   // test loads the hold_cycles counter, until that counter has run down.
   initial begin : result_sink
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (receiver_gaps_on && $urandom_range(0, 99) < 25) begin
            stall_left = pick_gap_length() - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("[%0t] result %0d: %s is %02h, expected %02h",
                  $time, results_checked, what, got, want);
   endtask

   // Every output transfer is matched against the oldest prediction.
   always @(posedge clock) begin : check_results
      alu_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected transfer, acc_out", rsp_ch.acc_out, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.acc_out !== want.acc)
               report_mismatch("acc_out", rsp_ch.acc_out, want.acc);
            if (rsp_ch.x_out !== want.x)
               report_mismatch("x_out", rsp_ch.x_out, want.x);
            if (rsp_ch.y_out !== want.y)
               report_mismatch("y_out", rsp_ch.y_out, want.y);
            if (rsp_ch.status_out !== want.status)
               report_mismatch("status_out", rsp_ch.status_out, want.status);
            if (rsp_ch.mem_out !== want.mem)
               report_mismatch("mem_out", rsp_ch.mem_out, want.mem);
            if (rsp_ch.bit_is_set !== want.bit_set)
               report_mismatch("bit_is_set", rsp_ch.bit_is_set, want.bit_set);
         end
         results_checked++;
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Walks every operation but CLC with edge-case operands. The first item
   // shows the reset state; the arithmetic part hits binary overflow, the
   // decimal high correction with carry out, a decimal add that needs no
   // high correction and must clear carry, and a decimal borrow that wraps
   // the 16-bit difference. The status pull sets bits 4 and 5, which must
   // not show up as anything but the fixed ones.
   task automatic test_directed_ops();
      sender_gaps_on   = 1'b0;
      receiver_gaps_on = 1'b0;
      send_op(CMD_BBX, 8'h01, 3'd0);
      send_op(CMD_LDA, 8'hFF, 3'd0);
      send_op(CMD_LDX, 8'h80, 3'd1);
      send_op(CMD_LDY, 8'h7F, 3'd2);
      send_op(CMD_CPX, 8'h80, 3'd3);
      send_op(CMD_CPY, 8'hFF, 3'd4);
      send_op(CMD_CMP, 8'h00, 3'd5);
      send_op(CMD_SEC, 8'h00, 3'd6);
      send_op(CMD_ADC, 8'h80, 3'd7);
      send_op(CMD_SBC, 8'h01, 3'd0);
      send_op(CMD_SED, 8'h00, 3'd0);
      send_op(CMD_LDA, 8'h99, 3'd0);
      send_op(CMD_ADC, 8'h01, 3'd0);
      send_op(CMD_ADC, 8'h00, 3'd0);
      send_op(CMD_SBC, 8'h99, 3'd0);
      send_op(CMD_CLD, 8'h00, 3'd0);
      send_op(CMD_AND, 8'h0F, 3'd0);
      send_op(CMD_ORA, 8'hF0, 3'd0);
      send_op(CMD_EOR, 8'hFF, 3'd0);
      send_op(CMD_BIT, 8'hC0, 3'd6);
      send_op(CMD_CLV, 8'h00, 3'd0);
      send_op(CMD_INC, 8'hFF, 3'd0);
      send_op(CMD_DEC, 8'h00, 3'd0);
      send_op(CMD_ASL, 8'h81, 3'd0);
      send_op(CMD_LSR, 8'h01, 3'd0);
      send_op(CMD_ROL, 8'h80, 3'd7);
      send_op(CMD_ROR, 8'h01, 3'd0);
      send_op(CMD_TRB, 8'hAA, 3'd1);
      send_op(CMD_TSB, 8'h55, 3'd2);
      send_op(CMD_RMB, 8'hFF, 3'd7);
      send_op(CMD_SMB, 8'h00, 3'd0);
      send_op(CMD_CLI, 8'h00, 3'd0);
      send_op(CMD_SEI, 8'h00, 3'd0);
      send_op(CMD_PLP, 8'hF7, 3'd3);
   endtask

   // Random operations of every kind with random gaps on both sides.
   task automatic test_random_mix(input int count);
      sender_gaps_on   = 1'b1;
      receiver_gaps_on = 1'b1;
      send_random_ops(count, 20);
   endtask

   // Same mix with no idling anywhere, so the block runs at full rate.
   task automatic test_back_to_back(input int count);
      sender_gaps_on   = 1'b0;
      receiver_gaps_on = 1'b0;
      send_random_ops(count, 20);
   endtask

   // Decimal-mode arithmetic on mostly valid BCD operands, reloading the
   // accumulator with BCD values now and then so that the corrections see
   // a wide spread of digit pairs.
   task automatic test_decimal_arith(input int count);
      sender_gaps_on   = 1'b1;
      receiver_gaps_on = 1'b1;
      send_op(CMD_SED, 8'h00, 3'd0);
      repeat (count) begin
         if ($urandom_range(0, 9) == 0)
            send_op(CMD_LDA, pick_operand(1'b1), INDEX_W'($urandom_range(0, 7)));
         else if (!flag_d && $urandom_range(0, 3) == 0)
            send_op(CMD_SED, pick_operand(1'b0), INDEX_W'($urandom_range(0, 7)));
         else
            send_random_ops(1, 70);
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering items, so the pipeline fills and input ready must drop.
   task automatic test_output_hold_off(input int count);
      sender_gaps_on   = 1'b0;
      receiver_gaps_on = 1'b0;
      hold_cycles      = HOLD_OFF_LEN;
      send_random_ops(count, 30);
      receiver_gaps_on = 1'b1;
   endtask

   // Bursts separated by pauses in which the sender waits until every
   // predicted result has arrived and the block is empty.
   task automatic test_drain_pauses(input int bursts);
      sender_gaps_on   = 1'b1;
      receiver_gaps_on = 1'b1;
      repeat (bursts) begin
         send_random_ops($urandom_range(10, 40), 25);
         drop_valid();
         wait_all_results();
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.cmd       = CMD_ADC;
      req_ch.operand   = '0;
      req_ch.bit_index = '0;
      clear_alu_state();

      // Synchronous reset held over rising edges, released on a falling one.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_ops();
      test_random_mix(350);
      test_back_to_back(200);
      test_decimal_arith(350);
      test_output_hold_off(40);
      test_drain_pauses(6);
      test_random_mix(150);

      // Let everything drain, then keep the clock running so that any stray
      // transfer can show up as a mismatch.
      drop_valid();
      wait_all_results();
      receiver_gaps_on = 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d operations over all opcodes, %0d of them decimal ADC/SBC,",
               items_sent, decimal_items);
      $display("with random gaps, a long output hold-off and drain pauses; %0d results checked.",
               results_checked);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatching fields", mismatch_count);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
